// ===== src/psrt_pkg.sv =====
// ----------------------------------------------------------------------------
// psrt_pkg: shared types and constants for the packet sample rate tracker
// Widths, defaults, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package psrt_pkg;
  localparam int STREAM_ENTRIES_DEF = 16;
  localparam int CHANNELS_DEF       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS     = 1'd1;
  localparam logic [13:0] SEQ_WRAP = 14'd9999;
  localparam logic [6:0]  THRESH_RESET = 7'd1;
  localparam logic [19:0] TICKS_RESET  = 20'd1000;

  typedef struct packed {
    logic [15:0] unit_id;
    logic [15:0] stream_id;
    logic [3:0]  channel;
    logic [13:0] seq_number;
    logic [47:0] timestamp;
    logic [15:0] sample_count;
  } psrt_req_t;

  typedef struct packed {
    logic        rate_valid;
    logic [31:0] sample_rate;
    logic        rate_changed;
    logic        seq_break;
    logic        table_full;
  } psrt_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_DECIDE, ST_CHAN_RD, ST_CHAN_WAIT,
    ST_MUL, ST_DIV, ST_UPDATE, ST_OUT
  } psrt_state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } psrt_div_ctl_t;
endpackage
`default_nettype wire

// ===== src/psrt_if.sv =====
// ----------------------------------------------------------------------------
// psrt_if: valid/ready channel
// Carries one request or one result with its handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface psrt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/packet_sample_rate_tracker.sv =====
// ----------------------------------------------------------------------------
// packet_sample_rate_tracker: per-stream sample rate estimator
// Looks up the (unit, stream) entry, keeps per-channel last time and count in
// RAM, and derives a Q16.16 rate with a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | unit_id stream_id channel seq_number timestamp sample_count
//  out_    | out | rate_valid sample_rate rate_changed seq_break table_full
//  cfg_    | in  | threshold pct (idx 0), ticks per second (idx 1)
//
// One request at a time. Scan: one entry RAM read per cycle over all
// STREAM_ENTRIES entries, then decide, channel RAM read and write-back. A
// computed rate adds load, 64 divider steps, done and update.
// Reset clears entry used/known and channel seen flags (flip-flops); RAM
// contents need no clearing. A stalled result holds in the output register;
// the next request is taken once that result is delivered.
`default_nettype none
module packet_sample_rate_tracker
  import psrt_pkg::*;
#(
  parameter int STREAM_ENTRIES = STREAM_ENTRIES_DEF,
  parameter int CHANNELS       = CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  psrt_if.sink                       in_ch,
  psrt_if.source                     out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int EW = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1;
  localparam int SLOTS = STREAM_ENTRIES * CHANNELS;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EC = EW + 1;
  localparam logic [EC-1:0] ENT_N = EC'(STREAM_ENTRIES);

  // config
  logic [6:0]  thr_r;
  logic [19:0] tps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET; tps_r <= TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THRESHOLD: thr_r <= cfg_data[6:0];
        REG_TICKS:     tps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  psrt_state_t st_r, st_nxt;
  psrt_req_t   req_r;
  psrt_rsp_t   rsp_r, rsp_nxt;
  logic [EC-1:0] idx_r, idx_nxt;
  logic [EC-1:0] found_r, found_nxt, free_r, free_nxt;
  logic [STREAM_ENTRIES-1:0] used_r, known_r;
  logic [SLOTS-1:0]          seen_r, seen_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [63:0]   num_r;
  logic [47:0]   den_r;
  logic [31:0]   nr_r;

  // entry RAM: {unit, stream, last_seq, rate}
  localparam int ENT_W = 16 + 16 + 14 + 32;
  logic          ent_we;
  logic [EW-1:0] ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata, ent_rdata;
  psrt_ram #(.WIDTH(ENT_W), .DEPTH(STREAM_ENTRIES)) u_ent (
    .clk, .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata));
  wire [15:0] rd_unit   = ent_rdata[77:62];
  wire [15:0] rd_stream = ent_rdata[61:46];
  wire [13:0] rd_seq    = ent_rdata[45:32];
  wire [31:0] rd_rate   = ent_rdata[31:0];

  // channel RAM: {time, count}
  logic          ch_we;
  logic [SW-1:0] slot;
  logic [63:0]   ch_rdata;
  psrt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_chan (
    .clk, .we(ch_we), .waddr(slot), .wdata({req_r.timestamp, req_r.sample_count}),
    .raddr(slot), .rdata(ch_rdata));
  wire [47:0] rd_time  = ch_rdata[63:16];
  wire [15:0] rd_count = ch_rdata[15:0];

  assign slot = SW'(int'(e_r) * CHANNELS + int'(req_r.channel));

  // entry word and new flag latched on decide, break flag on channel read
  logic [13:0] last_seq_r;
  logic [31:0] rate_r;
  logic        brk_r, is_new_r;

  // divider
  logic div_start;
  psrt_div_ctl_t div_ctl;
  logic [31:0] div_q;
  psrt_div u_div (.clk, .rst_n, .start(div_start), .num(num_r), .den(den_r),
                  .ctl(div_ctl), .quot(div_q));

  wire chan_ok  = int'(req_r.channel) < CHANNELS;
  wire seq_good = ({1'b0, req_r.seq_number} == {1'b0, last_seq_r} + 15'd1) ||
                  (last_seq_r == SEQ_WRAP && req_r.seq_number == '0);
  wire slot_seen = seen_r[slot] && !brk_r;
  wire later     = req_r.timestamp > rd_time;
  // change test on the fresh rate
  wire [31:0] base  = known_r[e_r] ? rate_r : div_q;
  wire [31:0] diff  = (div_q >= base) ? div_q - base : base - div_q;
  wire [38:0] lhs   = 39'(diff) * 39'd100;
  wire [38:0] rhs   = 39'(thr_r) * 39'(div_q);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:      if (in_ch.valid) st_nxt = ST_SCAN;
      ST_SCAN:      st_nxt = chan_ok ? ST_SCAN_WAIT : ST_OUT;
      ST_SCAN_WAIT: if (idx_r == ENT_N) st_nxt = ST_DECIDE;
      ST_DECIDE:    st_nxt = (found_r == ENT_N && free_r == ENT_N) ? ST_OUT : ST_CHAN_RD;
      ST_CHAN_RD:   st_nxt = ST_CHAN_WAIT;
      ST_CHAN_WAIT: st_nxt = (!is_new_r && slot_seen && later) ? ST_MUL : ST_OUT;
      ST_MUL:       st_nxt = ST_DIV;
      ST_DIV:       if (div_ctl.done) st_nxt = ST_UPDATE;
      ST_UPDATE:    st_nxt = ST_OUT;
      ST_OUT:       if (out_ch.ready) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt = idx_r; found_nxt = found_r; free_nxt = free_r; e_nxt = e_r;
    rsp_nxt = rsp_r; div_start = 1'b0;
    ent_we = 1'b0; ent_waddr = e_r; ent_raddr = idx_r[EW-1:0];
    ent_wdata = {req_r.unit_id, req_r.stream_id, req_r.seq_number, rate_r};
    ch_we = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        idx_nxt = '0; found_nxt = ENT_N; free_nxt = ENT_N; rsp_nxt = '0;
      end
      ST_SCAN: begin
        ent_raddr = '0; idx_nxt = EC'(1);
      end
      ST_SCAN_WAIT: begin
        // rdata belongs to entry idx_r-1
        if (used_r[idx_r[EW-1:0] - EW'(1)]) begin
          if (found_r == ENT_N && rd_unit == req_r.unit_id &&
              rd_stream == req_r.stream_id) begin
            found_nxt = idx_r - EC'(1);
          end
        end else if (free_r == ENT_N) begin
          free_nxt = idx_r - EC'(1);
        end
        if (idx_r != ENT_N) idx_nxt = idx_r + EC'(1);
        // last step: fetch the matching entry for decide
        if (idx_r == ENT_N) ent_raddr = found_nxt[EW-1:0];
      end
      ST_DECIDE: begin
        if (found_r == ENT_N && free_r == ENT_N) rsp_nxt.table_full = 1'b1;
        e_nxt = (found_r != ENT_N) ? found_r[EW-1:0] : free_r[EW-1:0];
      end
      ST_CHAN_RD: ;
      ST_CHAN_WAIT: begin
        rsp_nxt.seq_break = brk_r;
        ch_we = 1'b1; ent_we = 1'b1;
        if (is_new_r || !slot_seen || !later) begin
          if (!is_new_r && known_r[e_r] && rate_r != '0) begin
            rsp_nxt.rate_valid = 1'b1; rsp_nxt.sample_rate = rate_r;
          end
        end
      end
      ST_MUL: div_start = 1'b1;
      ST_UPDATE: begin
        ent_we = 1'b1;
        rsp_nxt.rate_valid = 1'b1;
        if (lhs > rhs) begin
          ent_wdata[31:0] = div_q; rsp_nxt.sample_rate = div_q;
          rsp_nxt.rate_changed = known_r[e_r];
        end else begin
          ent_wdata[31:0] = base; rsp_nxt.sample_rate = base;
        end
      end
      default: ;
    endcase
  end

  // channel seen flags: clear the stream on a new entry or a break, mark slot
  always_comb begin
    seen_nxt = seen_r;
    if (st_r == ST_CHAN_WAIT) begin
      if (is_new_r || brk_r) begin
        for (int c = 0; c < CHANNELS; c++) begin
          seen_nxt[SW'(int'(e_r) * CHANNELS + c)] = 1'b0;
        end
      end
      seen_nxt[slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; used_r <= '0; known_r <= '0; seen_r <= '0;
    end else begin
      st_r <= st_nxt;
      seen_r <= seen_nxt;
      if (st_r == ST_CHAN_WAIT) begin
        if (is_new_r) begin
          used_r[e_r] <= 1'b1; known_r[e_r] <= 1'b0;
        end
      end
      if (st_r == ST_UPDATE) known_r[e_r] <= 1'b1;
    end
    if (st_r == ST_IDLE && in_ch.valid) req_r <= in_ch.data;
    idx_r <= idx_nxt; found_r <= found_nxt; free_r <= free_nxt; e_r <= e_nxt;
    rsp_r <= rsp_nxt;
    if (st_r == ST_DECIDE) begin
      is_new_r   <= (found_r == ENT_N);
      last_seq_r <= rd_seq;
      rate_r     <= (found_r == ENT_N) ? 32'd0 : rd_rate;
    end
    if (st_r == ST_CHAN_RD) brk_r <= !is_new_r && !seq_good;
    if (st_r == ST_CHAN_WAIT) begin
      num_r <= {12'd0, 36'(rd_count) * 36'(tps_r), 16'd0};
      den_r <= req_r.timestamp - rd_time;
    end
  end

  assign in_ch.ready  = (st_r == ST_IDLE);
  assign out_ch.valid = (st_r == ST_OUT);
  assign out_ch.data  = rsp_r;

  // found and free never point at the same entry at decide
  a_decide: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DECIDE |-> (found_r == ENT_N || free_r == ENT_N ||
                           free_r < found_r || found_r < free_r))
    else $error("decide indexes inconsistent");
  a_full_norate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.table_full |-> !out_ch.data.rate_valid)
    else $error("full table reported a rate");
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.rate_changed |-> out_ch.data.rate_valid)
    else $error("change without rate");
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.done |-> st_r == ST_DIV)
    else $error("stray divider completion");
endmodule
`default_nettype wire

// ===== src/psrt_ram.sv =====
// ----------------------------------------------------------------------------
// psrt_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module psrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/psrt_div.sv =====
// ----------------------------------------------------------------------------
// psrt_div: restoring divider, one quotient bit per cycle
// 64-bit numerator over 48-bit divisor; quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module psrt_div
  import psrt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [63:0]   num,
  input  wire logic [47:0]   den,
  output psrt_div_ctl_t      ctl,
  output logic [31:0]        quot
);
  logic [63:0] n_r, n_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [48:0] trial;
  logic [49:0] sub;

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[47:0], n_r[63]};
    sub = {1'b0, trial} - {2'b0, den};
    if (start) begin
      n_nxt = num; rem_nxt = '0; q_nxt = '0; cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[62:0], 1'b0};
      if (!sub[49]) begin
        rem_nxt = sub[48:0]; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial; q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quot = (q_r[63:32] != '0) ? 32'hFFFF_FFFF : q_r[31:0];
endmodule
`default_nettype wire
